// ===== hdl/bfbp_pkg.sv =====
// Shared types, constants and helpers of the bitmap font block parser.
`default_nettype none

package bfbp_pkg;

    // Width of the saturating byte position counter.
    localparam int POSITION_BITS = 24;
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Width of the file length register.
    localparam int LEN_BITS = 24;

    // Width of the overflow sum: position plus a 32-bit block size, one carry bit.
    localparam int SUM_W = ((POSITION_BITS > 32) ? POSITION_BITS : 32) + 1;

    // Block layout.
    localparam int HDR_LEN     = 5;
    localparam int ENTRY_LEN   = 20;
    localparam int ENTRY_KEEP  = 18;
    localparam int METRIC_LEN  = 4;
    localparam int ENTRY_IDX_W = $clog2(ENTRY_LEN);

    localparam logic [2:0] HDR_LAST = 3'(HDR_LEN - 1);
    localparam logic [ENTRY_IDX_W-1:0] ENTRY_LAST  = ENTRY_IDX_W'(ENTRY_LEN - 1);
    localparam logic [ENTRY_IDX_W-1:0] METRIC_LAST = ENTRY_IDX_W'(METRIC_LEN - 1);
    localparam logic [ENTRY_IDX_W-1:0] METRIC_END  = ENTRY_IDX_W'(METRIC_LEN);

    localparam logic [7:0] BLK_COMMON = 8'd2;
    localparam logic [7:0] BLK_CHARS  = 8'd4;

    localparam logic [1:0] SIG_LAST = 2'd3;

    // Header byte slots inside the block header.
    localparam logic [2:0] HDR_TYPE  = 3'd0;
    localparam logic [2:0] HDR_SIZE0 = 3'd1;
    localparam logic [2:0] HDR_SIZE1 = 3'd2;
    localparam logic [2:0] HDR_SIZE2 = 3'd3;

    typedef enum logic [2:0] {
        KIND_GLYPH   = 3'd0,
        KIND_COMMON  = 3'd1,
        KIND_BAD_SIG = 3'd2,
        KIND_OVERRUN = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_SIG  = 4'b0001,
        PH_HEAD = 4'b0010,
        PH_BODY = 4'b0100,
        PH_HALT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       final_byte;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic               file_done;
        logic [15:0]        base_line;
        logic [15:0]        line_pitch;
        logic signed [15:0] advance_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] offset_x;
        logic [15:0]        glyph_height;
        logic [15:0]        glyph_width;
        logic [15:0]        atlas_y;
        logic [15:0]        atlas_x;
        logic [31:0]        glyph_id;
        kind_t              result_kind;
    } result_t;

    // Expected signature: 'B', 'M', 'F', 3.
    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h42;
            2'd1:    val = 8'h4D;
            2'd2:    val = 8'h46;
            default: val = 8'h03;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/bfbp_in_reg.sv =====
// Input register stage of the bitmap font block parser.
`default_nettype none

module bfbp_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire bfbp_pkg::item_t in_item,
    input  wire logic          proc_fire,
    output logic               hold_valid,
    output bfbp_pkg::item_t    hold_item
);
    import bfbp_pkg::*;

    logic  vld_reg;
    logic  vld_next;
    item_t item_reg;

    // Room when empty or when the held word moves on this cycle.
    assign in_ready = !vld_reg || proc_fire;

    always_comb
    begin
        vld_next = vld_reg;
        if (in_valid && in_ready)
        begin
            vld_next = 1'b1;
        end
        else if (proc_fire)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = vld_reg;
    assign hold_item  = item_reg;

endmodule

`default_nettype wire

// ===== hdl/bfbp_parse.sv =====
// Per-byte parse state and result logic of the bitmap font block parser.
`default_nettype none

module bfbp_parse (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          fire,
    input  wire bfbp_pkg::item_t               item,
    input  wire logic [bfbp_pkg::LEN_BITS-1:0] file_length,
    output logic                               res_valid,
    output bfbp_pkg::result_t                  res
);
    import bfbp_pkg::*;

    phase_t                   phase_reg,   phase_next;
    logic [1:0]               sig_idx_reg, sig_idx_next;
    logic [POSITION_BITS-1:0] pos_reg,     pos_next;
    logic [7:0]               type_reg,    type_next;
    logic [31:0]              rem_reg,     rem_next;
    logic [2:0]               hdr_idx_reg, hdr_idx_next;
    logic [ENTRY_IDX_W-1:0]   ent_idx_reg, ent_idx_next;
    logic [7:0]               entry_reg [ENTRY_KEEP];

    logic [POSITION_BITS-1:0] pos_inc;
    logic [31:0]              size_full;
    logic [31:0]              rem_dec;
    logic [SUM_W-1:0]         end_pos;
    logic                     ent_wr;
    logic [7:0]               b;

    assign b         = item.data_byte;
    assign pos_inc   = (pos_reg == POS_MAX) ? pos_reg : pos_reg + POSITION_BITS'(1);
    assign size_full = {b, rem_reg[23:0]};
    assign rem_dec   = rem_reg - 32'd1;
    assign end_pos   = SUM_W'(pos_inc) + SUM_W'(size_full);

    always_comb
    begin
        phase_next   = phase_reg;
        sig_idx_next = sig_idx_reg;
        pos_next     = pos_inc;
        type_next    = type_reg;
        rem_next     = rem_reg;
        hdr_idx_next = hdr_idx_reg;
        ent_idx_next = ent_idx_reg;
        ent_wr       = 1'b0;
        res_valid    = 1'b0;
        res          = '0;
        res.result_kind = KIND_DONE;

        case (phase_reg)
            PH_SIG:
            begin
                if (b != sig_byte(sig_idx_reg))
                begin
                    res_valid       = 1'b1;
                    res.result_kind = KIND_BAD_SIG;
                    phase_next      = PH_HALT;
                end
                else if (sig_idx_reg == SIG_LAST)
                begin
                    phase_next   = PH_HEAD;
                    hdr_idx_next = '0;
                end
                else
                begin
                    sig_idx_next = sig_idx_reg + 2'd1;
                end
            end
            PH_HEAD:
            begin
                // The size is assembled in the remaining-count register.
                case (hdr_idx_reg)
                    HDR_TYPE:  type_next       = b;
                    HDR_SIZE0: rem_next[7:0]   = b;
                    HDR_SIZE1: rem_next[15:8]  = b;
                    HDR_SIZE2: rem_next[23:16] = b;
                    default:   rem_next        = rem_reg;
                endcase
                if (hdr_idx_reg == HDR_LAST)
                begin
                    hdr_idx_next = '0;
                    if (end_pos > SUM_W'(file_length))
                    begin
                        res_valid       = 1'b1;
                        res.result_kind = KIND_OVERRUN;
                        phase_next      = PH_HALT;
                    end
                    else
                    begin
                        rem_next     = size_full;
                        ent_idx_next = '0;
                        phase_next   = (size_full != 32'd0) ? PH_BODY : PH_HEAD;
                    end
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
            end
            PH_BODY:
            begin
                rem_next = rem_dec;
                if (type_reg == BLK_COMMON)
                begin
                    if (ent_idx_reg < METRIC_END)
                    begin
                        ent_wr       = 1'b1;
                        ent_idx_next = ent_idx_reg + ENTRY_IDX_W'(1);
                        if (ent_idx_reg == METRIC_LAST)
                        begin
                            res_valid       = 1'b1;
                            res.result_kind = KIND_COMMON;
                            res.line_pitch  = {entry_reg[1], entry_reg[0]};
                            res.base_line   = {b, entry_reg[2]};
                        end
                    end
                end
                else if (type_reg == BLK_CHARS)
                begin
                    ent_wr = 1'b1;
                    if (ent_idx_reg == ENTRY_LAST)
                    begin
                        ent_idx_next     = '0;
                        res_valid        = 1'b1;
                        res.result_kind  = KIND_GLYPH;
                        res.glyph_id     = {entry_reg[3], entry_reg[2],
                                            entry_reg[1], entry_reg[0]};
                        res.atlas_x      = {entry_reg[5],  entry_reg[4]};
                        res.atlas_y      = {entry_reg[7],  entry_reg[6]};
                        res.glyph_width  = {entry_reg[9],  entry_reg[8]};
                        res.glyph_height = {entry_reg[11], entry_reg[10]};
                        res.offset_x     = {entry_reg[13], entry_reg[12]};
                        res.offset_y     = {entry_reg[15], entry_reg[14]};
                        res.advance_x    = {entry_reg[17], entry_reg[16]};
                    end
                    else
                    begin
                        ent_idx_next = ent_idx_reg + ENTRY_IDX_W'(1);
                    end
                end
                if (rem_dec == 32'd0)
                begin
                    phase_next = PH_HEAD;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase

        // The final byte always reports and restarts parsing for the next file.
        if (item.final_byte)
        begin
            if (!res_valid)
            begin
                res_valid       = 1'b1;
                res.result_kind = (phase_next == PH_SIG) ? KIND_BAD_SIG : KIND_DONE;
            end
            res.file_done = 1'b1;
            phase_next    = PH_SIG;
            sig_idx_next  = '0;
            pos_next      = '0;
            type_next     = '0;
            rem_next      = '0;
            hdr_idx_next  = '0;
            ent_idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SIG;
            sig_idx_reg <= '0;
            pos_reg     <= '0;
            type_reg    <= '0;
            rem_reg     <= '0;
            hdr_idx_reg <= '0;
            ent_idx_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            sig_idx_reg <= sig_idx_next;
            pos_reg     <= pos_next;
            type_reg    <= type_next;
            rem_reg     <= rem_next;
            hdr_idx_reg <= hdr_idx_next;
            ent_idx_reg <= ent_idx_next;
        end
    end

    // Entry bytes are always written before they are read; no reset needed.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRY_KEEP; i++)
        begin
            if (fire && ent_wr && ent_idx_reg == ENTRY_IDX_W'(i))
            begin
                entry_reg[i] <= b;
            end
        end
    end

`ifndef SYNTHESIS
    a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= HDR_LAST)
        else $error("header byte index out of range");

    a_ent_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        ent_idx_reg <= ENTRY_LAST)
        else $error("entry byte index out of range");

    a_body_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_BODY |-> rem_reg != 32'd0)
        else $error("body phase with no bytes left");

    a_final_restart: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.final_byte |=> phase_reg == PH_SIG && pos_reg == '0)
        else $error("parser did not restart after the final byte");
`endif

endmodule

`default_nettype wire

// ===== hdl/bfbp_out_reg.sv =====
// Result register stage of the bitmap font block parser.
`default_nettype none

module bfbp_out_reg (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                hold_valid,
    output logic                     proc_fire,
    input  wire logic                res_valid,
    input  wire bfbp_pkg::result_t   res,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bfbp_pkg::result_t        out_res
);
    import bfbp_pkg::*;

    logic    vld_reg;
    logic    vld_next;
    result_t res_reg;

    // A held byte is processed when the result slot is free or drains now.
    assign proc_fire = hold_valid && (!vld_reg || out_ready);

    always_comb
    begin
        vld_next = vld_reg;
        if (proc_fire)
        begin
            vld_next = res_valid;
        end
        else if (out_ready)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = vld_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== hdl/bitmap_font_block_parser_unit.sv =====
// Top level of the bitmap font block parser.
`default_nettype none

// Byte-serial parser for binary bitmap-font files (version 3 layout). Each input
// word carries one file byte, with tlast on the final byte. The first four bytes
// must read 'B', 'M', 'F', 3; after them come blocks of a type byte, a
// little-endian 32-bit size and the body. A common block (type 2) yields one
// metrics word with line height and base; a chars block (type 4) yields one
// glyph word per complete 20-byte entry. A wrong signature yields a bad
// signature word, and a block header whose block would run past file_length
// yields an overflow word; after either, bytes are ignored until the final byte.
// The final byte always yields a word with tlast set (a bad signature word if
// the file ends inside the signature, otherwise a done word if nothing else came
// from it) and restarts the parser; file_length is kept. While the output is
// not stalled, throughput is one byte per clock: every byte updates the parse
// state with a small counter and field step between the input register and
// the result register, which holds the result of the byte for the output. The
// input stalls only while a finished result waits at the output and the byte
// held in the input register must be processed. Write file_length on the
// configuration channel only while the parser is idle.
module bitmap_font_block_parser_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,

    // Configuration: file_length.
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [23:0]  cfg_data,      // file_length[23:0]

    // Input stream.
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [7:0]   s_axis_tdata,  // data_byte[7:0]
    input  wire logic         s_axis_tlast,  // final_byte

    // Result stream.
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // glyph_id[31:0], atlas_x[47:32], atlas_y[63:48], glyph_width[79:64],
    // glyph_height[95:80], offset_x[111:96], offset_y[127:112],
    // advance_x[143:128], line_pitch[159:144], base_line[175:160]
    output logic [175:0]      m_axis_tdata,
    output logic [2:0]        m_axis_tuser,  // result_kind[2:0]
    output logic              m_axis_tlast   // file_done
);
    import bfbp_pkg::*;

    logic [LEN_BITS-1:0] file_length_reg;
    item_t               in_item;
    item_t               hold_item;
    logic                hold_valid;
    logic                proc_fire;
    logic                res_valid;
    result_t             res;
    result_t             out_res;

    // The register is always ready to be written.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            file_length_reg <= cfg_data;
        end
    end

    assign in_item.data_byte  = s_axis_tdata;
    assign in_item.final_byte = s_axis_tlast;

    bfbp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .proc_fire  (proc_fire),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    bfbp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (proc_fire),
        .item        (hold_item),
        .file_length (file_length_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    bfbp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .proc_fire  (proc_fire),
        .res_valid  (res_valid),
        .res        (res),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_res    (out_res)
    );

    // Pack the result fields, first field in the lowest bits.
    assign m_axis_tdata = {out_res.base_line, out_res.line_pitch, out_res.advance_x,
                           out_res.offset_y, out_res.offset_x, out_res.glyph_height,
                           out_res.glyph_width, out_res.atlas_y, out_res.atlas_x,
                           out_res.glyph_id};
    assign m_axis_tuser = out_res.result_kind;
    assign m_axis_tlast = out_res.file_done;

`ifndef SYNTHESIS
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while the pipeline is blocked");

    a_fire_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |-> hold_valid)
        else $error("processing without a held word");

    a_result_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(proc_fire))
        else $error("result appeared without a processed word");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_bitmap_font_block_parser_unit.sv =====
// Self-checking testbench for the bitmap font block parser: directed table, then random font files.
`default_nettype none

module tb_bitmap_font_block_parser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import bfbp_pkg::*;

    // Run shape. The random part keeps going until the word count is reached
    // and the phase with the receiver hold-off has run.
    localparam int RANDOM_WORDS     = 400;
    localparam int MIN_PHASES       = 5;
    localparam int WORDS_PER_PHASE  = 60;
    // A byte's result passes through the input and result registers; the settle
    // wait lets a byte that yields nothing clear the pipeline before a register write.
    localparam int SETTLE_CYCLES    = 8;
    localparam int HOLD_OFF_CYCLES  = 250;
    localparam int CYCLE_LIMIT      = 300000;
    localparam int DIRECTED_ROWS    = 29;

    // 'B', 'M', 'F', 3 from the lowest byte up.
    localparam logic [31:0] FONT_MAGIC = 32'h03_46_4D_42;

    logic               clk;
    logic               rst_n;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [23:0]        cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;
    logic               s_axis_tlast;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [175:0]       m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               m_axis_tlast;

    bitmap_font_block_parser_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // One row of the directed table. When has_kind is set, the expected word
    // is typed in: that kind, all data fields zero, file_done equal to last.
    // Otherwise the parse model decides. A row with set_len first writes
    // file_length once the parser has gone idle.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        has_kind;
        kind_t       kind;
        logic        set_len;
        logic [23:0] len;
    } font_row_t;

    localparam logic [23:0] LEN_MAX = 24'hFFFFFF;

    font_row_t font_rows [DIRECTED_ROWS] = '{
        // file_length still at its reset value of zero.
        '{8'h42, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h58, 1'b0, 1'b1, KIND_BAD_SIG, 1'b0, 24'd0},   // 'X' instead of 'M'
        '{8'hFF, 1'b1, 1'b1, KIND_DONE,    1'b0, 24'd0},   // ignored until the end
        '{8'h42, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h4D, 1'b1, 1'b1, KIND_BAD_SIG, 1'b0, 24'd0},   // file ends inside signature
        '{8'h42, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h4D, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h46, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h03, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h01, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},   // block type 1, size 0
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b1, KIND_OVERRUN, 1'b0, 24'd0},   // header lies past the length
        '{8'hAA, 1'b1, 1'b1, KIND_DONE,    1'b0, 24'd0},
        // Largest file_length: a common block with extreme metrics.
        '{8'h42, 1'b0, 1'b0, KIND_DONE,    1'b1, LEN_MAX},
        '{8'h4D, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h46, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h03, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h02, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h04, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'hFF, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h80, 1'b0, 1'b0, KIND_DONE,    1'b0, 24'd0},
        '{8'h00, 1'b1, 1'b1, KIND_DONE,    1'b0, 24'd0}    // final byte opens a header
    };

    // Parse model state, kept in step with every accepted input word.
    phase_t                   font_phase;
    int                       magic_idx;
    logic [POSITION_BITS-1:0] byte_pos;
    logic [7:0]               blk_type;
    logic [31:0]              blk_size;
    logic [31:0]              blk_left;
    int                       hdr_idx;
    int                       entry_idx;
    logic [7:0]               entry_buf [ENTRY_LEN];
    logic [LEN_BITS-1:0]      font_len;

    // Words the parser still owes us, oldest first.
    result_t pending_words [$];

    logic [7:0] font_file [$];

    int error_count;
    int words_sent;
    int send_idle_pct;
    int sink_stall_pct;
    int hold_off_requests;
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Return the parse state to the start of a file; file_length is kept.
    function automatic void restart_parse();
        font_phase = PH_SIG;
        magic_idx  = 0;
        byte_pos   = '0;
        blk_type   = '0;
        blk_size   = '0;
        blk_left   = '0;
        hdr_idx    = 0;
        entry_idx  = 0;
        foreach (entry_buf[i])
            entry_buf[i] = '0;
    endfunction

    // Advance the parse model by one byte. Returns 1 when the byte yields a
    // word, which is then placed in word.
    function automatic bit parse_font_byte(input logic [7:0] b, input logic fin,
                                           output result_t word);
        bit    emits;
        kind_t kind;

        emits = 1'b0;
        kind  = KIND_DONE;
        word  = '0;

        if (byte_pos != POS_MAX)
            byte_pos++;

        case (font_phase)
            PH_SIG:
            begin
                if (b != FONT_MAGIC[8*magic_idx +: 8])
                begin
                    emits      = 1'b1;
                    kind       = KIND_BAD_SIG;
                    font_phase = PH_HALT;
                end
                else if (magic_idx == 3)
                begin
                    font_phase = PH_HEAD;
                    hdr_idx    = 0;
                end
                else
                begin
                    magic_idx++;
                end
            end
            PH_HEAD:
            begin
                if (hdr_idx == 0)
                begin
                    blk_type = b;
                    blk_size = '0;
                end
                else
                begin
                    blk_size[8*(hdr_idx-1) +: 8] = b;
                end
                hdr_idx++;
                if (hdr_idx == HDR_LEN)
                begin
                    hdr_idx = 0;
                    // The 64-bit sum keeps the carry of a huge block size.
                    if (64'(byte_pos) + 64'(blk_size) > 64'(font_len))
                    begin
                        emits      = 1'b1;
                        kind       = KIND_OVERRUN;
                        font_phase = PH_HALT;
                    end
                    else
                    begin
                        blk_left   = blk_size;
                        entry_idx  = 0;
                        font_phase = (blk_size != 0) ? PH_BODY : PH_HEAD;
                    end
                end
            end
            PH_BODY:
            begin
                blk_left--;
                if (blk_type == BLK_COMMON)
                begin
                    // Only the first four body bytes matter in a common block.
                    if (entry_idx < METRIC_LEN)
                    begin
                        entry_buf[entry_idx] = b;
                        entry_idx++;
                        if (entry_idx == METRIC_LEN)
                        begin
                            emits            = 1'b1;
                            kind             = KIND_COMMON;
                            word.line_pitch  = {entry_buf[1], entry_buf[0]};
                            word.base_line   = {entry_buf[3], entry_buf[2]};
                        end
                    end
                end
                else if (blk_type == BLK_CHARS)
                begin
                    entry_buf[entry_idx] = b;
                    entry_idx++;
                    if (entry_idx == ENTRY_LEN)
                    begin
                        entry_idx         = 0;
                        emits             = 1'b1;
                        kind              = KIND_GLYPH;
                        word.glyph_id     = {entry_buf[3], entry_buf[2],
                                             entry_buf[1], entry_buf[0]};
                        word.atlas_x      = {entry_buf[5], entry_buf[4]};
                        word.atlas_y      = {entry_buf[7], entry_buf[6]};
                        word.glyph_width  = {entry_buf[9], entry_buf[8]};
                        word.glyph_height = {entry_buf[11], entry_buf[10]};
                        word.offset_x     = {entry_buf[13], entry_buf[12]};
                        word.offset_y     = {entry_buf[15], entry_buf[14]};
                        word.advance_x    = {entry_buf[17], entry_buf[16]};
                    end
                end
                if (blk_left == 0)
                    font_phase = PH_HEAD;
            end
            default:
            begin
                // Halted: bytes are dropped until the final one.
            end
        endcase

        if (fin)
        begin
            if (!emits)
                kind = (font_phase == PH_SIG) ? KIND_BAD_SIG : KIND_DONE;
            emits          = 1'b1;
            word.file_done = 1'b1;
            restart_parse();
        end

        word.result_kind = kind;
        return emits;
    endfunction

    // Offer one byte, wait for it to be taken, then record what it should yield.
    task automatic send_font_byte(input logic [7:0] b, input logic fin,
                                  input logic has_kind, input kind_t kind);
        result_t word;
        bit      emits;

        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);

        words_sent++;
        emits = parse_font_byte(b, fin, word);
        if (has_kind)
        begin
            word             = '0;
            word.result_kind = kind;
            word.file_done   = fin;
            emits            = 1'b1;
        end
        if (emits)
            pending_words.push_back(word);
    endtask

    // Stop offering bytes and wait until every owed word has come out, plus the
    // settle wait for a byte that yields nothing to leave the pipeline.
    task automatic wait_parser_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_file_length(input logic [23:0] len);
        wait_parser_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        font_len = len;
    endtask

    // Build one random file in font_file. Most files are well formed with
    // random content; the rest are noise, a broken signature or cut short.
    task automatic build_font_file();
        int          roll;
        int          cut;
        int          body_len;
        logic [7:0]  btype;
        logic [31:0] bsize;

        font_file.delete();
        roll = $urandom_range(99);
        if (roll < 10)
        begin
            repeat ($urandom_range(1, 8))
                font_file.push_back(8'($urandom));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
                font_file.push_back(FONT_MAGIC[8*i +: 8]);
            if (roll < 20)
                font_file[$urandom_range(3)] ^= 8'($urandom_range(1, 255));

            repeat ($urandom_range(1, 3))
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                begin
                    // Chars block, sometimes with a partial entry at the end.
                    btype = BLK_CHARS;
                    bsize = 20 * $urandom_range(0, 2);
                    if ($urandom_range(3) == 0)
                        bsize += $urandom_range(1, 19);
                end
                else if (roll < 70)
                begin
                    // Common block, short ones included.
                    btype = BLK_COMMON;
                    bsize = $urandom_range(0, 6);
                end
                else
                begin
                    btype = 8'($urandom);
                    bsize = $urandom_range(0, 8);
                end
                // Now and then a size that runs far past any file length.
                if ($urandom_range(19) == 0)
                    bsize = $urandom;

                font_file.push_back(btype);
                for (int i = 0; i < 4; i++)
                    font_file.push_back(bsize[8*i +: 8]);

                body_len = (bsize <= 64) ? int'(bsize) : $urandom_range(1, 6);
                repeat (body_len)
                begin
                    // Lean on the extreme byte values so the 16-bit fields hit
                    // their limits and the signed fields go negative.
                    case ($urandom_range(7))
                        0, 1:    font_file.push_back(8'h00);
                        2, 3:    font_file.push_back(8'hFF);
                        4:       font_file.push_back(8'h80);
                        5:       font_file.push_back(8'h7F);
                        default: font_file.push_back(8'($urandom));
                    endcase
                end
            end

            // Cut some files anywhere: inside a header, a body or the signature.
            if ($urandom_range(3) == 0)
            begin
                cut = $urandom_range(1, font_file.size());
                while (font_file.size() > cut)
                    void'(font_file.pop_back());
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result side: the output words unpack straight into the package record,
    // with the kind in tuser and file_done in tlast.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'({m_axis_tlast, m_axis_tdata, m_axis_tuser});
            if (pending_words.size() == 0)
            begin
                $error("result word with no expectation: kind 0x%0h", m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
                compare_field("glyph_id", want.glyph_id, got.glyph_id);
                compare_field("atlas_x", 32'(want.atlas_x), 32'(got.atlas_x));
                compare_field("atlas_y", 32'(want.atlas_y), 32'(got.atlas_y));
                compare_field("glyph_width", 32'(want.glyph_width), 32'(got.glyph_width));
                compare_field("glyph_height", 32'(want.glyph_height),
                              32'(got.glyph_height));
                compare_field("offset_x", 32'(unsigned'(want.offset_x)),
                              32'(unsigned'(got.offset_x)));
                compare_field("offset_y", 32'(unsigned'(want.offset_y)),
                              32'(unsigned'(got.offset_y)));
                compare_field("advance_x", 32'(unsigned'(want.advance_x)),
                              32'(unsigned'(got.advance_x)));
                compare_field("line_pitch", 32'(want.line_pitch), 32'(got.line_pitch));
                compare_field("base_line", 32'(want.base_line), 32'(got.base_line));
                compare_field("file_done", 32'(want.file_done), 32'(got.file_done));
            end
        end
    end

    // Result sink. A hold-off request keeps tready low for a long stretch so
    // the parser fills up and must stall its input; otherwise it stalls at
    // random at the current rate.
    initial
    begin
        int hold_left;
        int hold_served;

        hold_left     = 0;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_off_requests)
            begin
                hold_served = hold_off_requests;
                hold_left   = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stimulus: reset, the directed table, then phases of random files with
    // different file lengths and idle patterns.
    initial
    begin
        int          phase_no;
        int          phase_start;
        logic [23:0] len;

        rst_n             = 1'b0;
        cfg_valid         = 1'b0;
        cfg_data          = '0;
        s_axis_tvalid     = 1'b0;
        s_axis_tdata      = '0;
        s_axis_tlast      = 1'b0;
        error_count       = 0;
        words_sent        = 0;
        send_idle_pct     = 0;
        sink_stall_pct    = 0;
        hold_off_requests = 0;
        font_len          = '0;
        restart_parse();

        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (font_rows[i])
        begin
            if (font_rows[i].set_len)
                write_file_length(font_rows[i].len);
            send_font_byte(font_rows[i].data, font_rows[i].last,
                           font_rows[i].has_kind, font_rows[i].kind);
        end

        phase_no = 0;
        while (words_sent < DIRECTED_ROWS + RANDOM_WORDS || phase_no < MIN_PHASES)
        begin
            case (phase_no % 6)
                0:       len = LEN_MAX;
                1:       len = 24'($urandom_range(40, 400));
                2:       len = 24'($urandom);
                3:       len = 24'($urandom_range(10, 60));
                4:       len = LEN_MAX;
                default: len = 24'd0;
            endcase
            write_file_length(len);

            // Idle patterns: none, sender only, receiver only, both.
            case (phase_no % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 54;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    sink_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct  = 31;
                    sink_stall_pct = 31;
                end
            endcase

            // Back pressure: the receiver holds off while bytes keep coming.
            if (phase_no == 4)
                hold_off_requests++;

            phase_start = words_sent;
            while (words_sent - phase_start < WORDS_PER_PHASE)
            begin
                build_font_file();
                foreach (font_file[i])
                    send_font_byte(font_file[i], i == font_file.size() - 1,
                                   1'b0, KIND_DONE);
                // In phase 3, the sender pauses after each file until everything has drained.
                if (phase_no == 3 && words_sent - phase_start < WORDS_PER_PHASE)
                    wait_parser_idle();
            end
            phase_no++;
        end

        wait_parser_idle();
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/bfbp_pkg.sv
hdl/bfbp_in_reg.sv
hdl/bfbp_parse.sv
hdl/bfbp_out_reg.sv
hdl/bitmap_font_block_parser_unit.sv
tb/tb_bitmap_font_block_parser_unit.sv
